[hw/rtl/csh_pkg.sv]
// Shared types and constants for the cloth stretch Hessian core.
package csh_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned FB = 16;

  localparam logic [0:0] REG_MU    = 1'b0;
  localparam logic [0:0] REG_CLAMP = 1'b1;

  typedef struct packed {
    logic signed [DW-1:0] col_u_x;
    logic signed [DW-1:0] col_u_y;
    logic signed [DW-1:0] col_u_z;
    logic signed [DW-1:0] col_v_x;
    logic signed [DW-1:0] col_v_y;
    logic signed [DW-1:0] col_v_z;
  } in_item_t;

  typedef struct packed {
    logic                 block_is_v;
    logic signed [DW-1:0] h_xx;
    logic signed [DW-1:0] h_yy;
    logic signed [DW-1:0] h_zz;
    logic signed [DW-1:0] h_xy;
    logic signed [DW-1:0] h_xz;
    logic signed [DW-1:0] h_yz;
    logic                 degenerate;
  } out_item_t;

  // One column on its way into the pipeline.
  typedef struct packed {
    logic        is_v;
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
    logic [2:0]  neg;
  } col_t;

  function automatic logic [DW-1:0] sat_out(input logic neg, input logic [63:0] m);
    logic [63:0] lim;
    lim = 64'(1) << (DW - 1);
    if (neg) return (m >= lim) ? DW'(lim) : DW'(~m + 64'd1);
    return (m >= lim) ? DW'(lim - 64'd1) : DW'(m);
  endfunction

endpackage

[hw/rtl/csh_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, QW by 32 bits.
module csh_divider #(
  parameter int unsigned QW = 48,
  parameter int unsigned TW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] num,
  input  logic [31:0]   den,
  input  logic [TW-1:0] tag_in,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] tag_out
);
  logic [QW-1:0] n_r [QW+1];
  logic [32:0]   r_r [QW+1];
  logic [31:0]   d_r [QW+1];
  logic [TW-1:0] t_r [QW+1];

  always_comb begin
    n_r[0] = num;
    r_r[0] = '0;
    d_r[0] = den;
    t_r[0] = tag_in;
  end

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [33:0] rem_sh;
    logic [33:0] diff;
    logic        ge;
    assign rem_sh = {r_r[k], n_r[k][QW-1]};
    assign diff = rem_sh - {2'b0, d_r[k]};
    assign ge = !diff[33];
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1] <= ge ? diff[32:0] : rem_sh[32:0];
        n_r[k+1] <= {n_r[k][QW-2:0], ge};
        d_r[k+1] <= d_r[k];
        t_r[k+1] <= t_r[k];
      end
    end
  end

  assign quo = n_r[QW];
  assign tag_out = t_r[QW];
endmodule

[hw/rtl/cloth_stretch_hessian_core.sv]
// Baraff-Witkin stretch Hessian top: one column per cycle unless stalled.
//
//  channel | ports                         | direction
//  input   | in_valid, in_stall, in_data   | one gradient per transaction
//  output  | out_valid, out_stall, out_data| two blocks per gradient, u first
//  config  | cfg_we, cfg_index, cfg_data   | register write
//
// An item is split into its two columns, u first, and no new item is taken
// while the v column goes in. Each column passes a squaring stage, a 32-stage
// square root, 48-stage dividers for 1/s and n, three multiply stages and
// the output register; the u block reaches the output first, then the v
// block. A stall freezes the whole pipeline; reset clears the valid bits and
// the half flag and sets mu and clamp to their defaults.
module cloth_stretch_hessian_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  csh_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output csh_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import csh_pkg::*;

  localparam int unsigned SQ = 32;
  localparam int unsigned QW = 48;
  localparam int unsigned DL = 1 + SQ + QW + 4;

  logic [31:0] mu_r;
  logic        clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r    <= 32'd65536;
      clamp_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MU:    mu_r    <= cfg_data;
        REG_CLAMP: clamp_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline advances unless the output holds a result the consumer stalls.
  logic adv;
  assign adv = !(out_valid && out_stall);

  // Front: hold the v column while the u column goes in.
  logic       half_r;
  logic [31:0] vx_r, vy_r, vz_r;
  logic       take;
  assign in_stall = !adv || half_r;
  assign take = in_valid && !in_stall;

  function automatic logic [31:0] mag32(input logic [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  // m_i <= s, so every n_i is at most 1.0 and fits 17 bits; c is at most 2^32.
  function automatic logic [16:0] nmul(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = 34'(a) * 34'(b);
    return p[FB+16:FB];
  endfunction

  function automatic logic [32:0] cmul(input logic [32:0] a, input logic [16:0] b);
    logic [49:0] p;
    p = 50'(a) * 50'(b);
    return p[FB+32:FB];
  endfunction

  function automatic logic [63:0] hmul(input logic [31:0] a, input logic [33:0] b);
    logic [65:0] p;
    p = 66'(a) * 66'(b);
    return 64'(p >> FB);
  endfunction

  col_t c0;
  logic c0_v;
  always_comb begin
    c0_v = take || half_r;
    if (half_r) begin
      c0.is_v = 1'b1;
      c0.mx = mag32(vx_r); c0.my = mag32(vy_r); c0.mz = mag32(vz_r);
      c0.neg = {vx_r[31], vy_r[31], vz_r[31]};
    end else begin
      c0.is_v = 1'b0;
      c0.mx = mag32(in_data.col_u_x); c0.my = mag32(in_data.col_u_y);
      c0.mz = mag32(in_data.col_u_z);
      c0.neg = {in_data.col_u_x[31], in_data.col_u_y[31], in_data.col_u_z[31]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) half_r <= 1'b0;
    else if (adv) half_r <= take;
    if (take) begin
      vx_r <= in_data.col_v_x; vy_r <= in_data.col_v_y; vz_r <= in_data.col_v_z;
    end
  end

  // Valid shift line, one bit per stage.
  logic [DL-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DL-2:0], c0_v};
  end

  // Stage A: squares; three squares of at most 2^31 stay below 2^64.
  col_t        a_c_r;
  logic [63:0] a_s2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a_c_r  <= c0;
      a_s2_r <= 64'(c0.mx) * 64'(c0.mx) + 64'(c0.my) * 64'(c0.my) +
                64'(c0.mz) * 64'(c0.mz);
    end
  end

  // Square root, two bits of radicand per stage.
  logic [63:0] sq_v_r [SQ+1];
  logic [31:0] sq_q_r [SQ+1];
  logic [67:0] sq_rm_r[SQ+1];
  col_t        sq_c_r [SQ+1];
  logic        sq_z_r [SQ+1];
  always_comb begin
    sq_v_r[0] = a_s2_r; sq_q_r[0] = '0; sq_rm_r[0] = '0;
    sq_c_r[0] = a_c_r;  sq_z_r[0] = (a_s2_r == '0);
  end
  for (genvar k = 0; k < SQ; k++) begin : g_sq
    logic [67:0] rr, tr;
    assign rr = {sq_rm_r[k][65:0], sq_v_r[k][63:62]};
    assign tr = rr - {34'b0, sq_q_r[k], 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_v_r[k+1] <= {sq_v_r[k][61:0], 2'b0};
        sq_rm_r[k+1] <= tr[67] ? rr : tr;
        sq_q_r[k+1] <= {sq_q_r[k][30:0], !tr[67]};
        sq_c_r[k+1] <= sq_c_r[k];
        sq_z_r[k+1] <= sq_z_r[k];
      end
    end
  end
  logic [31:0] s_root;
  assign s_root = sq_z_r[SQ] ? 32'd1 : sq_q_r[SQ];

  // Dividers: inv = 2^(2F)/s and n_i = m_i*2^F/s.
  localparam int unsigned TW = $bits(col_t) + 1;
  logic [QW-1:0] inv_q, nx_q, ny_q, nz_q;
  logic [TW-1:0] tag_q;
  logic [QW-1:0] n_inv;
  logic          tag_x, tag_y, tag_z;
  assign n_inv = QW'(64'(1) << (2*FB));

  csh_divider #(.QW(QW), .TW(TW)) u_div_inv (
    .clk(clk), .en(adv), .num(n_inv), .den(s_root),
    .tag_in({sq_c_r[SQ], sq_z_r[SQ]}), .quo(inv_q), .tag_out(tag_q));
  csh_divider #(.QW(QW), .TW(1)) u_div_x (
    .clk(clk), .en(adv), .num(QW'(sq_c_r[SQ].mx) << FB),
    .den(s_root), .tag_in(1'b0), .quo(nx_q), .tag_out(tag_x));
  csh_divider #(.QW(QW), .TW(1)) u_div_y (
    .clk(clk), .en(adv), .num(QW'(sq_c_r[SQ].my) << FB),
    .den(s_root), .tag_in(1'b0), .quo(ny_q), .tag_out(tag_y));
  csh_divider #(.QW(QW), .TW(1)) u_div_z (
    .clk(clk), .en(adv), .num(QW'(sq_c_r[SQ].mz) << FB),
    .den(s_root), .tag_in(1'b0), .quo(nz_q), .tag_out(tag_z));

  col_t d_c;
  logic d_z;
  assign d_c = tag_q[TW-1:1];
  assign d_z = tag_q[0];

  // Stage M1: d, c, n_i*n_j.
  logic [16:0] m1_nn_r [6];
  logic [5:0]  m1_sg_r;
  logic signed [63:0] m1_d_r;
  logic [32:0] m1_c_r;
  logic        m1_z_r, m1_isv_r;
  always_ff @(posedge clk) begin
    logic signed [63:0] dv;
    if (adv) begin
      dv = 64'sd65536 - $signed({16'b0, inv_q});
      if (clamp_r && dv < 0) begin
        m1_d_r <= '0; m1_c_r <= 33'd65536;
      end else begin
        m1_d_r <= dv; m1_c_r <= inv_q[32:0];
      end
      m1_nn_r[0] <= nmul(nx_q[16:0], nx_q[16:0]);
      m1_nn_r[1] <= nmul(ny_q[16:0], ny_q[16:0]);
      m1_nn_r[2] <= nmul(nz_q[16:0], nz_q[16:0]);
      m1_nn_r[3] <= nmul(nx_q[16:0], ny_q[16:0]);
      m1_nn_r[4] <= nmul(nx_q[16:0], nz_q[16:0]);
      m1_nn_r[5] <= nmul(ny_q[16:0], nz_q[16:0]);
      m1_sg_r <= {3'b000, d_c.neg[2]^d_c.neg[1], d_c.neg[2]^d_c.neg[0],
                  d_c.neg[1]^d_c.neg[0]};
      m1_z_r <= d_z;
      m1_isv_r <= d_c.is_v;
    end
  end

  // Stage M2: t = c*nn (+d on the diagonal), sign folded in.
  logic signed [63:0] m2_t_r [6];
  logic m2_z_r, m2_isv_r;
  always_ff @(posedge clk) begin
    logic [32:0] tm;
    logic signed [63:0] ts, sum;
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        tm = cmul(m1_c_r, m1_nn_r[i]);
        ts = m1_sg_r[5-i] ? -$signed(64'(tm)) : $signed(64'(tm));
        if (i < 3) begin
          sum = ts + m1_d_r;
          if (!ts[63] && !m1_d_r[63] && sum[63]) sum = 64'sh7FFF_FFFF_FFFF_FFFF;
          else if (ts[63] && m1_d_r[63] && !sum[63]) sum = {1'b1, 63'b0};
          m2_t_r[i] <= sum;
        end else begin
          m2_t_r[i] <= ts;
        end
      end
      m2_z_r <= m1_z_r; m2_isv_r <= m1_isv_r;
    end
  end

  // Stage M3: h = mu*t, saturated; |t| stays below 2^34.
  logic [31:0] m3_h_r [6];
  logic m3_z_r, m3_isv_r;
  always_ff @(posedge clk) begin
    logic [33:0] tmag;
    logic [63:0] hm;
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        tmag = m2_t_r[i][63] ? 34'(-m2_t_r[i]) : 34'(m2_t_r[i]);
        hm = hmul(mu_r, tmag);
        m3_h_r[i] <= (m2_z_r || hm == '0) ? '0 : sat_out(m2_t_r[i][63], hm);
      end
      m3_z_r <= m2_z_r; m3_isv_r <= m2_isv_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.block_is_v <= m3_isv_r;
      out_data.h_xx <= m3_h_r[0]; out_data.h_yy <= m3_h_r[1];
      out_data.h_zz <= m3_h_r[2]; out_data.h_xy <= m3_h_r[3];
      out_data.h_xz <= m3_h_r[4]; out_data.h_yz <= m3_h_r[5];
      out_data.degenerate <= m3_z_r;
    end
  end
  assign out_valid = vld_r[DL-1];

  logic unused;
  assign unused = ^{tag_x, tag_y, tag_z};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.h_xx == '0 && out_data.h_xy == '0)
    else $error("degenerate block not zero");
  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> in_stall)
    else $error("input taken during second column");
endmodule

[test/cloth_stretch_hessian_core_tb.sv]
// Testbench for the cloth stretch Hessian core: directed table plus random gradients.
module cloth_stretch_hessian_core_tb;
  import csh_pkg::*;

  localparam int LATENCY = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_MU;
  logic [31:0] cfg_data = '0;

  cloth_stretch_hessian_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("cloth_stretch_hessian_core_tb NOT OK");
    $finish;
  end

  // predictor copy of the registers
  logic [31:0] mu_q = 32'h10000;
  logic clamp_q = 1'b1;

  out_item_t expected_blocks[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  function automatic logic signed [63:0] sat_mag(input logic neg, input logic [63:0] m);
    if (m[63]) m = 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [127:0] p;
    logic [63:0] m;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    m = (p[127:80] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[79:16];
    return sat_mag(a[63] != b[63], m);
  endfunction

  function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] r;
    r = 65'(a) + 65'(b);
    if (r > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (r < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return r[63:0];
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_item_t hessian_block(input logic is_v, input logic signed [31:0] cx,
                                              input logic signed [31:0] cy,
                                              input logic signed [31:0] cz);
    out_item_t o;
    logic signed [63:0] w[3], n[3], h[6], d, c, t;
    logic [63:0] m[3], s2, s, inv;
    int ri[6], ci[6];
    ri = '{0, 1, 2, 0, 0, 1};
    ci = '{0, 1, 2, 1, 2, 2};
    o = '0;
    o.block_is_v = is_v;
    w[0] = cx; w[1] = cy; w[2] = cz;
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(w[i]);
      s2 += m[i] * m[i];
    end
    if (s2 == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    s = root64(s2);
    inv = (64'd1 << 32) / s;
    d = 64'sh10000 - $signed(inv);
    c = $signed(inv);
    if (clamp_q && d < 0) begin
      d = 0;
      c = 64'sh10000;
    end
    for (int i = 0; i < 3; i++) n[i] = sat_mag(w[i] < 0, (m[i] << 16) / s);
    for (int i = 0; i < 6; i++) begin
      t = qmul(c, qmul(n[ri[i]], n[ci[i]]));
      if (i < 3) t = qadd(t, d);
      h[i] = qmul($signed({32'd0, mu_q}), t);
    end
    o.h_xx = clip32(h[0]); o.h_yy = clip32(h[1]); o.h_zz = clip32(h[2]);
    o.h_xy = clip32(h[3]); o.h_xz = clip32(h[4]); o.h_yz = clip32(h[5]);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // receiver side: stall pattern plus optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("unexpected transaction", 32'd0, 32'd0);
      end else begin
        e = expected_blocks.pop_front();
        if (out_data.block_is_v !== e.block_is_v)
          report_mismatch("block_is_v", 32'(out_data.block_is_v), 32'(e.block_is_v));
        if (out_data.degenerate !== e.degenerate)
          report_mismatch("degenerate", 32'(out_data.degenerate), 32'(e.degenerate));
        if (out_data.h_xx !== e.h_xx) report_mismatch("h_xx", out_data.h_xx, e.h_xx);
        if (out_data.h_yy !== e.h_yy) report_mismatch("h_yy", out_data.h_yy, e.h_yy);
        if (out_data.h_zz !== e.h_zz) report_mismatch("h_zz", out_data.h_zz, e.h_zz);
        if (out_data.h_xy !== e.h_xy) report_mismatch("h_xy", out_data.h_xy, e.h_xy);
        if (out_data.h_xz !== e.h_xz) report_mismatch("h_xz", out_data.h_xz, e.h_xz);
        if (out_data.h_yz !== e.h_yz) report_mismatch("h_yz", out_data.h_yz, e.h_yz);
      end
    end
  end

  // valid stays high across back-to-back transactions; it drops only while idle
  task automatic send_gradient(input in_item_t g, input bit use_table,
                               input out_item_t eu, input out_item_t ev);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= g;
    if (use_table) begin
      expected_blocks.push_back(eu);
      expected_blocks.push_back(ev);
    end else begin
      expected_blocks.push_back(hessian_block(1'b0, g.col_u_x, g.col_u_y, g.col_u_z));
      expected_blocks.push_back(hessian_block(1'b1, g.col_v_x, g.col_v_y, g.col_v_z));
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MU) mu_q = val;
    else clamp_q = val[0];
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return 32'($signed($urandom_range(8192)) - 4096);
      3: return 32'h0;
      4: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  typedef struct {
    in_item_t g;
    bit typed;
    out_item_t eu;
    out_item_t ev;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    in_item_t g;
    out_item_t zu, zv;
    zu = '0; zu.degenerate = 1'b1;
    zv = zu; zv.block_is_v = 1'b1;

    // degenerate both columns: answer typed in
    r.g = '0; r.typed = 1; r.eu = zu; r.ev = zv; rows.push_back(r);
    r.typed = 0;
    r.g = '{32'h10000, 0, 0, 0, 32'h10000, 0}; rows.push_back(r);
    r.g = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h80000000, 32'h80000000, 32'h80000000}; rows.push_back(r);
    r.g = '{32'h1, 0, 0, 0, 0, 32'hFFFFFFFF}; rows.push_back(r);
    r.g = '{32'h8000, 32'h8000, 0, 32'h20000, 32'hFFFE0000, 32'h30000}; rows.push_back(r);
    r.g = '{32'h80000000, 0, 0, 0, 0, 0}; rows.push_back(r);
    r.g = '{0, 0, 0, 32'h4000, 32'hFFFFC000, 32'h100}; rows.push_back(r);
    r.g = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h5555, 32'hAAAA, 32'h12345};
    rows.push_back(r);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) write_reg(REG_CLAMP, 32'h0);
      if (ph == 2) write_reg(REG_MU, 32'hFFFFFFFF);
      if (ph == 3) begin
        write_reg(REG_MU, 32'h0);
        write_reg(REG_CLAMP, 32'hFFFFFFFE);
      end
      foreach (rows[i]) begin
        if (rows[i].typed || ph == 0) send_gradient(rows[i].g, rows[i].typed,
                                                    rows[i].eu, rows[i].ev);
        else send_gradient(rows[i].g, 0, zu, zv);
      end
      drain_and_settle();
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      write_reg(REG_MU, (ph == 4) ? 32'($urandom) : {15'd0, 17'($urandom)});
      write_reg(REG_CLAMP, 32'($urandom));
      if (ph == 2) hold_cycles = 400;
      repeat (270) begin
        for (int k = 0; k < $bits(in_item_t) / 32; k++) g[k*32 +: 32] = rand_comp();
        send_gradient(g, 0, zu, zv);
      end
      drain_and_settle();
      write_reg(REG_MU, 32'h10000);
    end

    if (errors == 0) $display("cloth_stretch_hessian_core_tb OK");
    else $display("cloth_stretch_hessian_core_tb NOT OK");
    $finish;
  end

endmodule
